// ===== rtl/hse_pkg.sv =====
// ----------------------------------------------------------------------------
// Heap sort engine package
// Shared types, codes and defaults for the controller and the datapath.
// ----------------------------------------------------------------------------
package hse_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int WORD_W    = 32;

	typedef logic signed [WORD_W-1:0] word_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_SORT_INIT,
		ST_SD_RD1,
		ST_SD_RD2,
		ST_SD_CMP,
		ST_SD_W1,
		ST_SD_W2,
		ST_SIFT_END,
		ST_SWAP_RD,
		ST_SWAP_W1,
		ST_SWAP_W2,
		ST_EMIT_RD,
		ST_EMIT_LD
	} state_t;

	typedef enum logic [3:0] {
		OP_IDLE,
		OP_LOAD,
		OP_SORT_INIT,
		OP_SD_RD1,
		OP_SD_RD2,
		OP_SD_CMP,
		OP_SD_W1,
		OP_SD_W2,
		OP_NEXT_ROOT,
		OP_TO_EXTRACT,
		OP_NEXT_K,
		OP_SWAP_RD,
		OP_SWAP_W1,
		OP_SWAP_W2,
		OP_EMIT_RD,
		OP_EMIT_LD
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic n_small;    // fewer than two entries stored
		logic sift_done;  // current node already outranks its children
		logic root_zero;  // heap build reached the top
		logic k_one;      // last extraction step done
		logic emit_last;  // emit index points at the final entry
		logic out_free;   // output register can take a beat
	} sts_t;

endpackage

// ===== rtl/hse_ctrl.sv =====
// ----------------------------------------------------------------------------
// Heap sort engine controller
// Sequences load, heap build, extraction and emit through the datapath.
// ----------------------------------------------------------------------------
module hse_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_last,
	output logic          in_ready,
	input  hse_pkg::sts_t sts,
	output hse_pkg::cmd_t cmd
);
	import hse_pkg::*;

	state_t state_q, state_d;
	logic   build_q, build_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			build_q <= 1'b0;
		end else begin
			state_q <= state_d;
			build_q <= build_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		build_d  = build_q;
		in_ready = 1'b0;
		cmd.op   = OP_IDLE;
		case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = OP_LOAD;
					if (in_last) begin
						state_d = ST_SORT_INIT;
					end
				end
			end
			ST_SORT_INIT: begin
				cmd.op  = OP_SORT_INIT;
				build_d = 1'b1;
				state_d = sts.n_small ? ST_EMIT_RD : ST_SD_RD1;
			end
			ST_SD_RD1: begin
				cmd.op  = OP_SD_RD1;
				state_d = ST_SD_RD2;
			end
			ST_SD_RD2: begin
				cmd.op  = OP_SD_RD2;
				state_d = ST_SD_CMP;
			end
			ST_SD_CMP: begin
				cmd.op  = OP_SD_CMP;
				state_d = sts.sift_done ? ST_SIFT_END : ST_SD_W1;
			end
			ST_SD_W1: begin
				cmd.op  = OP_SD_W1;
				state_d = ST_SD_W2;
			end
			ST_SD_W2: begin
				cmd.op  = OP_SD_W2;
				state_d = ST_SD_RD1;
			end
			ST_SIFT_END: begin
				if (build_q) begin
					if (sts.root_zero) begin
						cmd.op  = OP_TO_EXTRACT;
						build_d = 1'b0;
						state_d = ST_SWAP_RD;
					end else begin
						cmd.op  = OP_NEXT_ROOT;
						state_d = ST_SD_RD1;
					end
				end else if (sts.k_one) begin
					state_d = ST_EMIT_RD;
				end else begin
					cmd.op  = OP_NEXT_K;
					state_d = ST_SWAP_RD;
				end
			end
			ST_SWAP_RD: begin
				cmd.op  = OP_SWAP_RD;
				state_d = ST_SWAP_W1;
			end
			ST_SWAP_W1: begin
				cmd.op  = OP_SWAP_W1;
				state_d = ST_SWAP_W2;
			end
			ST_SWAP_W2: begin
				cmd.op  = OP_SWAP_W2;
				state_d = ST_SD_RD1;
			end
			ST_EMIT_RD: begin
				cmd.op  = OP_EMIT_RD;
				state_d = ST_EMIT_LD;
			end
			ST_EMIT_LD: begin
				cmd.op = OP_EMIT_LD;
				if (sts.out_free) begin
					state_d = sts.emit_last ? ST_LOAD : ST_EMIT_RD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

endmodule

// ===== rtl/hse_dp.sv =====
// ----------------------------------------------------------------------------
// Heap sort engine datapath
// Element store with two read ports, heap indexes, compare and output register.
// ----------------------------------------------------------------------------
module hse_dp #(
	parameter int DEPTH = hse_pkg::DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  hse_pkg::cmd_t  cmd,
	output hse_pkg::sts_t  sts,
	input  hse_pkg::word_t in_value,
	input  logic           out_ready,
	output logic           out_valid,
	output hse_pkg::word_t out_value,
	output logic           out_last,
	output logic           out_ovf
);
	import hse_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = AW + 2;

	word_t          mem [DEPTH];
	word_t          rd_a_q, rd_b_q;
	logic [AW-1:0]  raddr_a, raddr_b, waddr;
	logic           we;
	word_t          wdata;

	logic [CW-1:0]  count_q, hn_q, half_m1;
	logic           dropped_q;
	logic [AW-1:0]  node_q, root_q, k_q, emit_q, big_idx_q;
	word_t          node_val_q, big_val_q, tmp_q;
	logic [IW-1:0]  lc, rc, hn_ext;
	logic           lc_in, rc_in, rc_wins, out_free, emit_last;

	logic           out_valid_q;
	word_t          out_value_q;
	logic           out_last_q, out_ovf_q;

	assign lc        = IW'({node_q, 1'b1});
	assign rc        = lc + IW'(1);
	assign hn_ext    = IW'(hn_q);
	assign lc_in     = lc < hn_ext;
	assign rc_in     = rc < hn_ext;
	assign rc_wins   = rc_in && (rd_b_q > big_val_q);
	assign out_free  = !out_valid_q || out_ready;
	assign emit_last = CW'(emit_q) == (count_q - CW'(1));
	assign half_m1   = (count_q >> 1) - CW'(1);

	assign sts.n_small   = count_q < CW'(2);
	assign sts.sift_done = !rc_wins && (big_idx_q == node_q);
	assign sts.root_zero = root_q == '0;
	assign sts.k_one     = k_q == AW'(1);
	assign sts.emit_last = emit_last;
	assign sts.out_free  = out_free;

	// read and write address selection
	always_comb begin
		raddr_a = node_q;
		raddr_b = lc[AW-1:0];
		we      = 1'b0;
		waddr   = node_q;
		wdata   = big_val_q;
		case (cmd.op)
			OP_LOAD: begin
				we    = count_q < CW'(DEPTH);
				waddr = count_q[AW-1:0];
				wdata = in_value;
			end
			OP_SD_RD2: begin
				raddr_b = rc[AW-1:0];
			end
			OP_SD_W1: begin
				we = 1'b1;
			end
			OP_SD_W2: begin
				we    = 1'b1;
				waddr = big_idx_q;
				wdata = node_val_q;
			end
			OP_SWAP_RD: begin
				raddr_a = '0;
				raddr_b = k_q;
			end
			OP_SWAP_W1: begin
				we    = 1'b1;
				waddr = '0;
				wdata = rd_b_q;
			end
			OP_SWAP_W2: begin
				we    = 1'b1;
				waddr = k_q;
				wdata = tmp_q;
			end
			OP_EMIT_RD, OP_EMIT_LD: begin
				raddr_a = emit_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_a_q <= mem[raddr_a];
		rd_b_q <= mem[raddr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			dropped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == OP_LOAD) begin
				if (count_q < CW'(DEPTH)) begin
					count_q <= count_q + CW'(1);
				end else begin
					dropped_q <= 1'b1;
				end
			end
			// batch ends once its final beat enters the output register
			if (cmd.op == OP_EMIT_LD && out_free && emit_last) begin
				count_q   <= '0;
				dropped_q <= 1'b0;
			end
			if (cmd.op == OP_EMIT_LD && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_SORT_INIT: begin
				root_q <= half_m1[AW-1:0];
				node_q <= half_m1[AW-1:0];
				hn_q   <= count_q;
				emit_q <= '0;
			end
			OP_SD_RD2: begin
				node_val_q <= rd_a_q;
				if (lc_in && (rd_b_q > rd_a_q)) begin
					big_idx_q <= lc[AW-1:0];
					big_val_q <= rd_b_q;
				end else begin
					big_idx_q <= node_q;
					big_val_q <= rd_a_q;
				end
			end
			OP_SD_CMP: begin
				if (rc_wins) begin
					big_idx_q <= rc[AW-1:0];
					big_val_q <= rd_b_q;
				end
			end
			OP_SD_W2: begin
				node_q <= big_idx_q;
			end
			OP_NEXT_ROOT: begin
				root_q <= root_q - AW'(1);
				node_q <= root_q - AW'(1);
			end
			OP_TO_EXTRACT: begin
				k_q <= AW'(hn_q - CW'(1));
			end
			OP_NEXT_K: begin
				k_q <= k_q - AW'(1);
			end
			OP_SWAP_W1: begin
				tmp_q <= rd_a_q;
			end
			OP_SWAP_W2: begin
				hn_q   <= CW'(k_q);
				node_q <= '0;
			end
			OP_EMIT_LD: begin
				if (out_free) begin
					out_value_q <= rd_a_q;
					out_last_q  <= emit_last;
					out_ovf_q   <= dropped_q;
					if (!emit_last) begin
						emit_q <= emit_q + AW'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign out_last  = out_last_q;
	assign out_ovf   = out_ovf_q;

endmodule

// ===== rtl/heap_sort_engine_core.sv =====
// Load: one beat per cycle; the beat marked tlast starts the sort.
// Sort: each sift level reads a node and its children, compares, writes both on a swap;
//   a sift end step follows, and each extraction adds a root swap, all via the write port.
// Emit: each beat is read via the store's registered read port, then registered for output.
// Reset clears the controller, the batch count and overflow flag and the output valid;
//   the element store is not cleared and only written entries are used.
// ----------------------------------------------------------------------------
// Heap sort engine
// Collects a batch of signed words, heap-sorts it in place, emits it ascending.
// ----------------------------------------------------------------------------
module heap_sort_engine_core #(
	parameter int DEPTH = hse_pkg::DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic signed [31:0]    s_axis_tdata,  // [31:0] value
	input  logic                  s_axis_tlast,  // last
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic signed [31:0]    m_axis_tdata,  // [31:0] value_res
	output logic                  m_axis_tlast,  // last_res
	output logic                  m_axis_tuser   // [0] overflow
);
	import hse_pkg::*;

	cmd_t cmd;
	sts_t sts;

	hse_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_last  (s_axis_tlast),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	hse_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_value  (s_axis_tdata),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_value (m_axis_tdata),
		.out_last  (m_axis_tlast),
		.out_ovf   (m_axis_tuser)
	);

endmodule

// ===== rtl/hse_checker.sv =====
// ----------------------------------------------------------------------------
// Heap sort engine checker
// Port-level assertions on the batch sequencing of the engine.
// ----------------------------------------------------------------------------
module hse_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               s_axis_tvalid,
	input logic               s_axis_tready,
	input logic               s_axis_tlast,
	input logic               m_axis_tvalid,
	input logic               m_axis_tready,
	input logic signed [31:0] m_axis_tdata,
	input logic               m_axis_tlast,
	input logic               m_axis_tuser
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tlast) && $stable(m_axis_tuser))
		else $error("result beat changed while stalled");

	// input is not ready right after the closing beat of a batch
	a_last_stops_load: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
		else $error("input taken right after the closing beat");

	// no loading while a result beat before the last of a batch is pending
	a_no_load_mid_emit: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
		else $error("input ready while a batch is still emitting");

	// a second check that input is not ready after the closing beat of a batch
	a_emit_before_load: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=> ##1 !s_axis_tready)
		else $error("input ready before any result of the batch");

endmodule

bind heap_sort_engine_core hse_checker u_hse_checker (.*);
